[hw/rtl/cdu_pkg.sv]
// Shared constants, control types and month tables for the calendar date unit.
package cdu_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 23;
  localparam int DAYNUM_W = 22;
  localparam int ZSUM_W  = 11;
  localparam int ZOD_W   = 4;
  localparam int WDAY_W  = 3;
  localparam int MKT_W   = 3;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  localparam logic [YEAR_W-1:0] YEAR_LIMIT = 14'd9999;

  // x / 100 == (x * INV100) >> INV100_SHIFT for x below 2^15
  localparam int INV100_W     = 13;
  localparam logic [INV100_W-1:0] INV100 = 13'd5243;
  localparam int INV100_SHIFT = 19;
  localparam int QUOT_W       = 8;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic adv_a;  // load first register stage
    logic adv_b;  // load second register stage
  } pipe_ctl_t;

  // Days in all months before the given one; months 13..15 count 31 days.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      4'd13:   r = 9'd365;
      4'd14:   r = 9'd396;
      default: r = 9'd427;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd2:                     r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
      default:                  r = 5'd31;
    endcase
    return r;
  endfunction

  // First day of the later sign within each month.
  function automatic logic [DAY_W-1:0] zodiac_start(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd1:    r = 5'd20;
      4'd2:    r = 5'd19;
      4'd3:    r = 5'd21;
      4'd4:    r = 5'd20;
      4'd5:    r = 5'd21;
      4'd6:    r = 5'd21;
      4'd7:    r = 5'd23;
      4'd8:    r = 5'd23;
      4'd9:    r = 5'd23;
      4'd10:   r = 5'd23;
      4'd11:   r = 5'd22;
      4'd12:   r = 5'd22;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // floor(13 * (mm + 1) / 5), January and February as months 13 and 14
  function automatic logic [5:0] zeller_month_term(input logic [MONTH_W-1:0] m);
    logic [5:0] r;
    unique case (m)
      4'd1:    r = 6'd36;
      4'd2:    r = 6'd39;
      4'd3:    r = 6'd10;
      4'd4:    r = 6'd13;
      4'd5:    r = 6'd15;
      4'd6:    r = 6'd18;
      4'd7:    r = 6'd20;
      4'd8:    r = 6'd23;
      4'd9:    r = 6'd26;
      4'd10:   r = 6'd28;
      4'd11:   r = 6'd31;
      4'd12:   r = 6'd33;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/cdu_day_count.sv]
// Two-stage day number and validity datapath for one date.
module cdu_day_count (
  input  logic                          clk,
  input  cdu_pkg::pipe_ctl_t            ctl,
  input  logic [cdu_pkg::DAY_W-1:0]     day,
  input  logic [cdu_pkg::MONTH_W-1:0]   month,
  input  logic [cdu_pkg::YEAR_W-1:0]    year,
  output logic [cdu_pkg::COUNT_W-1:0]   count_r,
  output logic                          valid_r
);

  localparam int PROD_W = cdu_pkg::YEAR_W + cdu_pkg::INV100_W;

  // stage A
  logic [cdu_pkg::DAY_W-1:0]   day_r;
  logic [cdu_pkg::MONTH_W-1:0] month_r;
  logic [cdu_pkg::YEAR_W-1:0]  year_r;
  logic [cdu_pkg::YEAR_W-1:0]  prev_r, prev_nxt;
  logic [PROD_W-1:0]           prod_prev_r, prod_prev_nxt;
  logic [PROD_W-1:0]           prod_year_r, prod_year_nxt;

  always_comb begin
    prev_nxt      = (year == '0) ? '0 : year - 1'b1;
    prod_prev_nxt = PROD_W'(prev_nxt) * PROD_W'(cdu_pkg::INV100);
    prod_year_nxt = PROD_W'(year) * PROD_W'(cdu_pkg::INV100);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_a) begin
      day_r       <= day;
      month_r     <= month;
      year_r      <= year;
      prev_r      <= prev_nxt;
      prod_prev_r <= prod_prev_nxt;
      prod_year_r <= prod_year_nxt;
    end
  end

  // stage B
  logic [cdu_pkg::QUOT_W-1:0]  q_prev, q_year;
  logic [cdu_pkg::YEAR_W-1:0]  rem_year;
  logic                        leap;
  logic [cdu_pkg::COUNT_W-1:0] count_nxt;
  logic                        valid_nxt;

  always_comb begin
    q_prev   = prod_prev_r[cdu_pkg::INV100_SHIFT +: cdu_pkg::QUOT_W];
    q_year   = prod_year_r[cdu_pkg::INV100_SHIFT +: cdu_pkg::QUOT_W];
    rem_year = year_r - cdu_pkg::YEAR_W'(q_year) * cdu_pkg::YEAR_W'(100);
    leap     = ((year_r[1:0] == 2'b00) && (rem_year != '0)) ||
               ((rem_year == '0) && (q_year[1:0] == 2'b00));
    count_nxt = cdu_pkg::COUNT_W'(prev_r) * cdu_pkg::COUNT_W'(365)
              + cdu_pkg::COUNT_W'(prev_r >> 2)
              - cdu_pkg::COUNT_W'(q_prev)
              + cdu_pkg::COUNT_W'(q_prev >> 2)
              + cdu_pkg::COUNT_W'(cdu_pkg::days_before_month(month_r))
              + cdu_pkg::COUNT_W'(day_r)
              + cdu_pkg::COUNT_W'(leap && (month_r > cdu_pkg::MONTH_FEB));
    valid_nxt = (month_r >= cdu_pkg::MONTH_JAN) && (month_r <= cdu_pkg::MONTH_DEC) &&
                (day_r != '0) && (day_r <= cdu_pkg::month_length(month_r, leap)) &&
                (year_r <= cdu_pkg::YEAR_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_b) begin
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

[hw/rtl/cdu_weekday.sv]
// Two-stage Zeller sum and zodiac sign datapath for the first date.
module cdu_weekday (
  input  logic                          clk,
  input  cdu_pkg::pipe_ctl_t            ctl,
  input  logic [cdu_pkg::DAY_W-1:0]     day,
  input  logic [cdu_pkg::MONTH_W-1:0]   month,
  input  logic [cdu_pkg::YEAR_W-1:0]    year,
  output logic [cdu_pkg::ZSUM_W-1:0]    zsum_r,
  output logic [cdu_pkg::ZOD_W-1:0]     zodiac_r
);

  localparam int YY_W   = cdu_pkg::YEAR_W + 1;
  localparam int PROD_W = YY_W + cdu_pkg::INV100_W;

  // stage A: shift by 400 years, January and February belong to the prior year
  logic [cdu_pkg::DAY_W-1:0]   day_r;
  logic [cdu_pkg::MONTH_W-1:0] month_r;
  logic [YY_W-1:0]             yy_r, yy_nxt;
  logic [PROD_W-1:0]           prod_r, prod_nxt;

  always_comb begin
    yy_nxt   = YY_W'(year) + YY_W'(400) - YY_W'(month < 4'd3);
    prod_nxt = PROD_W'(yy_nxt) * PROD_W'(cdu_pkg::INV100);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_a) begin
      day_r   <= day;
      month_r <= month;
      yy_r    <= yy_nxt;
      prod_r  <= prod_nxt;
    end
  end

  // stage B
  logic [cdu_pkg::QUOT_W-1:0] cent;
  logic [6:0]                 yoc;
  logic                       month_ok;
  logic [cdu_pkg::ZSUM_W-1:0] zsum_nxt;
  logic [cdu_pkg::ZOD_W-1:0]  zodiac_nxt;

  always_comb begin
    cent     = prod_r[cdu_pkg::INV100_SHIFT +: cdu_pkg::QUOT_W];
    yoc      = 7'(yy_r - YY_W'(cent) * YY_W'(100));
    month_ok = (month_r >= cdu_pkg::MONTH_JAN) && (month_r <= cdu_pkg::MONTH_DEC);
    zsum_nxt = cdu_pkg::ZSUM_W'(day_r)
             + cdu_pkg::ZSUM_W'(cdu_pkg::zeller_month_term(month_r))
             + cdu_pkg::ZSUM_W'(yoc)
             + cdu_pkg::ZSUM_W'(yoc >> 2)
             + cdu_pkg::ZSUM_W'(cent >> 2)
             + cdu_pkg::ZSUM_W'(cent) * cdu_pkg::ZSUM_W'(5);
    if (day_r < cdu_pkg::zodiac_start(month_r)) begin
      zodiac_nxt = month_r - 1'b1;
    end else if (month_r == cdu_pkg::MONTH_DEC) begin
      zodiac_nxt = '0;
    end else begin
      zodiac_nxt = month_r;
    end
    // zero both for a month outside the calendar
    if (!month_ok) begin
      zsum_nxt   = '0;
      zodiac_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_b) begin
      zsum_r   <= zsum_nxt;
      zodiac_r <= zodiac_nxt;
    end
  end

endmodule

[hw/rtl/calendar_date_unit.sv]
// Calendar date unit: three-stage pipeline from a date pair to weekday, sign and day numbers.
//
// Usage: present a date pair as one word on the in_ channel; one result word
// comes back on the out_ channel for each accepted word, in order.
// Stage 1 forms the year offsets and the divide-by-100 products, stage 2 builds
// the day counts, leap and validity flags and the Zeller sum, stage 3 reduces
// mod 5 and mod 7, saturates the day numbers and subtracts them.
// An accepted word passes the stage 1, stage 2 and out_ registers, in that order, before out_tvalid shows it.
// Throughput: one word per cycle while out_tready stays high; the
// out_ register is the last stage, and a waiting result blocks input once all stages are full.
// Each stage loads whenever it is empty or the stage after it moves.
// Stall: with out_tready low the pipeline fills up to three words, then
// in_tready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties all stages; payload is not cleared.
module calendar_date_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [4:0] first_day, [8:5] first_month, [22:9] first_year,
  // [27:23] second_day, [31:28] second_month, [45:32] second_year, [47:46] zero
  input  logic [cdu_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] first_valid, [1] second_valid, [4:2] weekday, [8:5] zodiac_sign,
  // [11:9] market_day, [33:12] day_number, [56:34] day_difference, [63:57] zero
  output logic [cdu_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int W = cdu_pkg::COUNT_W;

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;
  cdu_pkg::pipe_ctl_t ctl;

  always_comb begin
    adv3       = !v3_r || out_tready;
    adv2       = !v2_r || adv3;
    adv1       = !v1_r || adv2;
    in_tready  = adv1;
    ctl.adv_a  = adv1;
    ctl.adv_b  = adv2;
    out_tvalid = v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  logic [cdu_pkg::DAY_W-1:0]   d1, d2;
  logic [cdu_pkg::MONTH_W-1:0] m1, m2;
  logic [cdu_pkg::YEAR_W-1:0]  y1, y2;

  assign d1 = in_tdata[4:0];
  assign m1 = in_tdata[8:5];
  assign y1 = in_tdata[22:9];
  assign d2 = in_tdata[27:23];
  assign m2 = in_tdata[31:28];
  assign y2 = in_tdata[45:32];

  logic [W-1:0]                n1_r, n2_r;
  logic                        val1_r, val2_r;
  logic [cdu_pkg::ZSUM_W-1:0]  zsum_r;
  logic [cdu_pkg::ZOD_W-1:0]   zod_r;

  cdu_day_count u_count1 (
    .clk(clk), .ctl(ctl), .day(d1), .month(m1), .year(y1),
    .count_r(n1_r), .valid_r(val1_r)
  );

  cdu_day_count u_count2 (
    .clk(clk), .ctl(ctl), .day(d2), .month(m2), .year(y2),
    .count_r(n2_r), .valid_r(val2_r)
  );

  cdu_weekday u_wday (
    .clk(clk), .ctl(ctl), .day(d1), .month(m1), .year(y1),
    .zsum_r(zsum_r), .zodiac_r(zod_r)
  );

  // stage 3: digit-sum reductions (16 = 1 mod 5, 8 = 1 mod 7)
  logic [6:0]                   m5_a;
  logic [4:0]                   m5_b;
  logic [cdu_pkg::MKT_W-1:0]    mkt_nxt;
  logic [4:0]                   m7_a;
  logic [3:0]                   m7_b;
  logic [cdu_pkg::WDAY_W-1:0]   wday_nxt;
  logic [cdu_pkg::DAYNUM_W-1:0] s1, s2;
  logic [W-1:0]                 diff_nxt;

  always_comb begin
    m5_a = 7'(n1_r[3:0]) + 7'(n1_r[7:4]) + 7'(n1_r[11:8]) + 7'(n1_r[15:12])
         + 7'(n1_r[19:16]) + 7'(n1_r[22:20]);
    m5_b = 5'(m5_a[3:0]) + 5'(m5_a[6:4]);
    if (m5_b >= 5'd20)      mkt_nxt = 3'(m5_b - 5'd20);
    else if (m5_b >= 5'd15) mkt_nxt = 3'(m5_b - 5'd15);
    else if (m5_b >= 5'd10) mkt_nxt = 3'(m5_b - 5'd10);
    else if (m5_b >= 5'd5)  mkt_nxt = 3'(m5_b - 5'd5);
    else                    mkt_nxt = 3'(m5_b);

    m7_a = 5'(zsum_r[2:0]) + 5'(zsum_r[5:3]) + 5'(zsum_r[8:6]) + 5'(zsum_r[10:9]);
    m7_b = 4'(m7_a[2:0]) + 4'(m7_a[4:3]);
    wday_nxt = (m7_b >= 4'd7) ? 3'(m7_b - 4'd7) : 3'(m7_b);

    // hold day numbers at the top of their range
    s1 = n1_r[W-1] ? '1 : n1_r[cdu_pkg::DAYNUM_W-1:0];
    s2 = n2_r[W-1] ? '1 : n2_r[cdu_pkg::DAYNUM_W-1:0];
    diff_nxt = {1'b0, s2} - {1'b0, s1};
  end

  logic [cdu_pkg::OUT_DATA_W-1:0] out_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      out_r <= {7'd0, diff_nxt, s1, mkt_nxt, zod_r, wday_nxt, val2_r, val1_r};
    end
  end

  assign out_tdata = out_r;

endmodule
